// ===== hw/rtl/shtp_pkg.sv =====
// Shared types, constants and the crypt ROM contents for the string hash table probe.
`default_nettype none
package shtp_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam int LEN_W = SLOT_W + 1;
   localparam int ROM_WORDS = 1280;
   localparam int HASH_W = 32;
   localparam int CFG_W = 11;
   localparam int OUT_SLOT_W = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [HASH_W-1:0] SEED_ONE_INIT = 32'h7FED_7FED;
   localparam logic [HASH_W-1:0] SEED_TWO_INIT = 32'hEEEE_EEEE;
   localparam logic [CFG_W-1:0] TABLE_LENGTH_RESET = 11'd1024;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      REQ_LOOKUP = 1'b0,
      REQ_INSERT = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      PS_CLEAR,
      PS_IDLE,
      PS_DIV,
      PS_READ,
      PS_CHECK,
      PS_OUT
   } probe_state_type;

   typedef struct packed {
      logic              req_type;
      logic [HASH_W-1:0] hash0;
      logic [HASH_W-1:0] hash1;
      logic [HASH_W-1:0] hash2;
   } job_type;

   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] check_a;
      logic [HASH_W-1:0] check_b;
   } slot_entry_type;

   typedef logic [HASH_W-1:0] crypt_rom_type [ROM_WORDS];

   function automatic crypt_rom_type build_crypt_rom();
      crypt_rom_type rom;
      logic [31:0]   x;
      logic [31:0]   hi;
      logic [31:0]   lo;
      x = 32'h0010_0001;
      for (int r = 0; r < 256; r++) begin
         for (int k = 0; k < 5; k++) begin
            x = (x * 32'd125 + 32'd3) % 32'h002A_AAAB;
            hi = (x & 32'h0000_FFFF) << 16;
            x = (x * 32'd125 + 32'd3) % 32'h002A_AAAB;
            lo = x & 32'h0000_FFFF;
            rom[r + k * 256] = hi | lo;
         end
      end
      return rom;
   endfunction

   localparam crypt_rom_type CRYPT_ROM = build_crypt_rom();

endpackage
`default_nettype wire

// ===== hw/rtl/shtp_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none
interface shtp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] char_byte;
   logic       last_char;
   modport source (output valid, output req_type, output char_byte, output last_char,
                   input ready);
   modport sink (input valid, input req_type, input char_byte, input last_char,
                 output ready);
endinterface

interface shtp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [9:0] slot;
   modport source (output valid, output status, output slot, input ready);
   modport sink (input valid, input status, input slot, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/shtp_hash.sv =====
// Front end: upper-cases each byte and runs the three crypt-table hashes.
`default_nettype none
module shtp_hash
   import shtp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire logic    req_type,
   input  wire logic [7:0] char_byte,
   input  wire logic    last_char,
   output      logic    job_push,
   output      job_type job_data
);

   logic [HASH_W-1:0] seed_one_ff [3];
   logic [HASH_W-1:0] seed_two_ff [3];
   logic [HASH_W-1:0] seed_one_in [3];
   logic [HASH_W-1:0] seed_two_in [3];
   logic [7:0]        ch;

   always_comb begin
      ch = char_byte;
      if (char_byte inside {[8'h61:8'h7A]}) begin
         ch = char_byte - 8'h20;
      end
      for (int t = 0; t < 3; t++) begin
         seed_one_in[t] = seed_one_ff[t];
         seed_two_in[t] = seed_two_ff[t];
         if (char_byte != 8'd0) begin
            seed_one_in[t] = CRYPT_ROM[11'((t << 8) + int'(ch))]
                             ^ (seed_one_ff[t] + seed_two_ff[t]);
            seed_two_in[t] = HASH_W'(ch) + seed_one_in[t] + seed_two_ff[t]
                             + (seed_two_ff[t] << 5) + 32'd3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < 3; t++) begin
            seed_one_ff[t] <= SEED_ONE_INIT;
            seed_two_ff[t] <= SEED_TWO_INIT;
         end
      end else if (accept) begin
         for (int t = 0; t < 3; t++) begin
            // drop back to the seed values once the string is handed off
            seed_one_ff[t] <= last_char ? SEED_ONE_INIT : seed_one_in[t];
            seed_two_ff[t] <= last_char ? SEED_TWO_INIT : seed_two_in[t];
         end
      end
   end

   assign job_push = accept && last_char;
   assign job_data = '{req_type: req_type, hash0: seed_one_in[0],
                       hash1: seed_one_in[1], hash2: seed_one_in[2]};

endmodule
`default_nettype wire

// ===== hw/rtl/shtp_queue.sv =====
// Two-entry job queue between the hash front end and the probe engine.
`default_nettype none
module shtp_queue
   import shtp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   input  wire logic    pop,
   output      job_type pop_data,
   output      logic    full,
   output      logic    empty
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

endmodule
`default_nettype wire

// ===== hw/rtl/shtp_probe.sv =====
// Back end: slot memory clearing, start-slot modulo and linear probing.
`default_nettype none
module shtp_probe
   import shtp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CFG_W-1:0] table_length,
   input  wire logic             job_valid,
   input  wire job_type          job_data,
   output      logic             job_pop,
   output      logic             clearing,
   shtp_rsp_if.source            rsp
);

   probe_state_type state_ff, state_in;

   slot_entry_type slot_mem [TABLE_DEPTH];
   slot_entry_type rd_data_ff;
   slot_entry_type wr_data;
   logic [SLOT_W-1:0] wr_addr;
   logic              wr_en;

   job_type           job_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic [SLOT_W-1:0] clr_addr_ff;
   logic [HASH_W-1:0] dvd_ff;
   logic [SLOT_W-1:0] rem_ff;
   logic [SLOT_W:0]   rem_sh;
   logic [SLOT_W-1:0] rem_in;
   logic [4:0]        div_cnt_ff;
   logic [SLOT_W-1:0] pos_ff;
   logic [SLOT_W-1:0] start_ff;
   logic [LEN_W-1:0]  pos_p1;
   logic [SLOT_W-1:0] pos_next;
   logic              hit;
   logic              finish;
   status_type        status_in;
   status_type        status_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              rsp_valid_ff;

   always_comb begin
      len_in = LEN_W'(table_length);
      if (table_length == '0) begin
         len_in = LEN_W'(1);
      end else if (32'(table_length) > TABLE_DEPTH) begin
         len_in = LEN_W'(TABLE_DEPTH);
      end
   end

   // restoring remainder, one dividend bit per cycle
   assign rem_sh = {rem_ff, dvd_ff[HASH_W-1]};
   assign rem_in = (rem_sh >= len_ff) ? SLOT_W'(rem_sh - len_ff) : SLOT_W'(rem_sh);

   assign pos_p1   = LEN_W'(pos_ff) + LEN_W'(1);
   assign pos_next = (pos_p1 == len_ff) ? '0 : SLOT_W'(pos_p1);
   assign hit = rd_data_ff.valid && (rd_data_ff.check_a == job_ff.hash1)
                && (rd_data_ff.check_b == job_ff.hash2);

   always_comb begin
      finish    = 1'b0;
      status_in = ST_NOT_FOUND;
      if (job_ff.req_type == REQ_INSERT) begin
         if (!rd_data_ff.valid) begin
            finish    = 1'b1;
            status_in = ST_INSERTED;
         end else if (pos_next == start_ff) begin
            finish    = 1'b1;
            status_in = ST_FULL;
         end
      end else begin
         if (!rd_data_ff.valid) begin
            finish = 1'b1;
         end else if (hit) begin
            finish    = 1'b1;
            status_in = ST_FOUND;
         end else if (pos_next == start_ff) begin
            finish = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         PS_CLEAR: if (clr_addr_ff == SLOT_W'(TABLE_DEPTH - 1)) state_in = PS_IDLE;
         PS_IDLE:  if (job_valid) state_in = PS_DIV;
         PS_DIV:   if (div_cnt_ff == 5'd31) state_in = PS_READ;
         PS_READ:  state_in = PS_CHECK;
         PS_CHECK: state_in = finish ? PS_OUT : PS_READ;
         PS_OUT:   if (!rsp_valid_ff || rsp.ready) state_in = PS_IDLE;
         default:  state_in = PS_CLEAR;
      endcase
   end

   always_comb begin
      job_pop  = 1'b0;
      clearing = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = '{valid: 1'b1, check_a: job_ff.hash1, check_b: job_ff.hash2};
      case (state_ff)
         PS_CLEAR: begin
            clearing = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = clr_addr_ff;
            wr_data  = '0;
         end
         PS_IDLE:  job_pop = job_valid;
         PS_CHECK: wr_en = (job_ff.req_type == REQ_INSERT) && !rd_data_ff.valid;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         PS_IDLE: begin
            job_ff     <= job_data;
            len_ff     <= len_in;
            dvd_ff     <= job_data.hash0;
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
         PS_DIV: begin
            dvd_ff     <= dvd_ff << 1;
            rem_ff     <= rem_in;
            div_cnt_ff <= div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               pos_ff   <= rem_in;
               start_ff <= rem_in;
            end
         end
         PS_CHECK: begin
            pos_ff      <= pos_next;
            status_ff   <= status_in;
            res_slot_ff <= (status_in == ST_INSERTED || status_in == ST_FOUND) ? pos_ff : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PS_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == PS_CLEAR) clr_addr_ff <= clr_addr_ff + SLOT_W'(1);
         if (state_ff == PS_OUT && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   logic [1:0]            rsp_status_ff;
   logic [OUT_SLOT_W-1:0] rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (state_ff == PS_OUT && (!rsp_valid_ff || rsp.ready)) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= OUT_SLOT_W'(res_slot_ff);
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.slot   = rsp_slot_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/string_hash_table_probe.sv =====
// Top level of the string hash table probe: hash front end, job queue, probe engine.
`default_nettype none
// Strings arrive one byte per req transaction; letters a..z are upper-cased and a
// zero byte leaves the hashes untouched. Bytes are hashed at one per cycle, while req
// is ready, by three crypt-table hashes running in parallel. The transaction carrying
// last_char hands the string to a two-entry queue; the probe engine then derives the
// start slot as hash0 mod table_length with a one-bit-per-cycle remainder unit and
// probes the slot memory, each slot visit passing through a read and a check state,
// and one rsp transaction (status, slot) comes back per string. Insert stores
// hash1/hash2 in the first free slot or reports table full; lookup walks occupied
// slots for a match. table_length 0 acts as 1 and values above 1024 act as 1024;
// write csr only while idle. After reset the engine sweeps the 1024-slot memory to
// clear the valid marks, holding req not ready during the sweep.
module string_hash_table_probe
   import shtp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data,
   shtp_req_if.sink              req_chan,
   shtp_rsp_if.source            rsp_chan
);

   logic [CFG_W-1:0] table_length_ff;
   logic             accept;
   logic             clearing;
   job_type          push_data;
   job_type          pop_data;
   logic             job_push;
   logic             job_pop;
   logic             queue_full;
   logic             queue_empty;

   // hold the table length register
   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= TABLE_LENGTH_RESET;
      end else if (csr_wr_en) begin
         table_length_ff <= csr_wr_data;
      end
   end

   // stall bytes while the queue is full or the memory is still clearing
   assign req_chan.ready = !queue_full && !clearing;
   assign accept = req_chan.valid && req_chan.ready;

   shtp_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_chan.req_type),
      .char_byte (req_chan.char_byte),
      .last_char (req_chan.last_char),
      .job_push  (job_push),
      .job_data  (push_data)
   );

   shtp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .pop       (job_pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   shtp_probe u_probe (
      .clock        (clock),
      .reset        (reset),
      .table_length (table_length_ff),
      .job_valid    (!queue_empty),
      .job_data     (pop_data),
      .job_pop      (job_pop),
      .clearing     (clearing),
      .rsp          (rsp_chan)
   );

`ifndef SYNTH
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_chan.ready) else $error("req accepted during clear sweep");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !job_push) else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      queue_empty |-> !job_pop) else $error("job queue underflow");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == ST_FULL || rsp_chan.status == ST_NOT_FOUND)
      |-> rsp_chan.slot == '0) else $error("nonzero slot on miss");
`endif

endmodule
`default_nettype wire
